FILE: rtl/core/lfir_pkg.sv
// Shared constants and types for the linear fade-in ramp.
package lfir_pkg;

   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 24;
   localparam int DATA_BITS   = CHANNELS * SAMPLE_BITS;
   localparam int REQ_USER_BITS = 3;

   localparam int CNT_BITS   = 12;
   localparam int GAIN_BITS  = 16;
   localparam int RATE_BITS  = 19;
   localparam int CHAN_BITS  = 2;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = RATE_BITS;

   localparam int DVD_BITS   = 29;
   localparam int QUO_BITS   = 17;
   localparam int STEP_BITS  = 5;
   localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS;

   localparam logic [1:0] OP_FRAME   = 2'd0;
   localparam logic [1:0] OP_FADE_IN = 2'd1;
   localparam logic [1:0] OP_CANCEL  = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] REG_SAMPLE_RATE = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ACTIVE_CH   = 1'd1;

   localparam logic [RATE_BITS-1:0] RATE_RESET = 19'd48000;
   localparam logic [CHAN_BITS-1:0] CHAN_RESET = 2'd2;

   localparam logic [CNT_BITS-1:0]  RATE_DIV   = 12'd100;
   localparam logic [RATE_BITS:0]   RATE_ROUND = 20'd50;
   localparam logic [CNT_BITS-1:0]  LEN_MAX    = 12'd4095;
   localparam logic [STEP_BITS-1:0] RATE_STEPS = 5'd20;
   localparam logic [STEP_BITS-1:0] GAIN_STEPS = 5'd17;

   typedef struct packed {
      logic [CNT_BITS-1:0]  rem_init;
      logic [DVD_BITS-1:0]  dividend;
      logic [CNT_BITS-1:0]  divisor;
      logic [STEP_BITS-1:0] steps;
   } div_req_type;

endpackage

FILE: rtl/core/linear_fade_in_ramp_top.sv
// Linear fade-in gain ramp for two-channel audio frames: top level.
//
// One item is in work at a time. A cancel request or an unused opcode leaves
// the block idle. A fade-in request runs the 20-step bit-serial divide of the
// sample rate by 100. A frame outside a ramp, or the last frame of a ramp,
// skips the divider and multipliers. A frame inside a ramp first runs the
// serial divider for the Q0.16 gain, then the bit-serial multiplier lanes
// (one per channel, in parallel). Results wait in an output register, so the
// next item is taken while a result is stalled; a frame that finishes while
// that register is still full waits.
module linear_fade_in_ramp_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lfir_pkg::DATA_BITS-1:0]        req_tdata,  // sample_left, sample_right
   input  logic [lfir_pkg::REQ_USER_BITS-1:0]    req_tuser,  // opcode[1:0], block_start
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lfir_pkg::DATA_BITS-1:0]        rsp_tdata,  // scaled_left, scaled_right
   output logic                                  rsp_tuser,  // ramp_active
   input  logic                                  csr_we,
   input  logic [lfir_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [lfir_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import lfir_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LEN  = 5'b00010,
      ST_GAIN = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [RATE_BITS-1:0]   rate_ff, rate_in;
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   logic [CNT_BITS-1:0]    pending_ff, pending_in;
   logic [CNT_BITS-1:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0]    total_ff, total_in;
   logic                   active_ff, active_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff [CHANNELS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   logic                   accept;
   logic [1:0]             op;
   logic                   take;
   logic [CNT_BITS-1:0]    rem_src, tot_src, rc, num, rem_next;
   logic                   live, act;
   logic [RATE_BITS:0]     rate_sum;
   logic [CNT_BITS-1:0]    ramp_len;
   logic                   load_out;

   div_req_type            div_req;
   logic                   div_start, div_busy, div_done;
   logic [QUO_BITS-1:0]    div_q;
   logic                   mul_start;
   logic [CHANNELS-1:0]    mul_done;
   logic signed [SAMPLE_BITS-1:0] mul_res [CHANNELS];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tuser[1:0];

   // frame bookkeeping, evaluated on the accepted item
   assign take     = req_tuser[2] && (pending_ff != '0);
   assign rem_src  = take ? pending_ff : rem_ff;
   assign tot_src  = take ? pending_ff : total_ff;
   assign live     = (rem_src != '0) && (tot_src != '0);
   assign rc       = (rem_src < tot_src) ? rem_src : tot_src;
   assign num      = tot_src - rc + 1'b1;
   assign rem_next = rc - 1'b1;
   assign act      = live && (rc > 12'd1);

   assign rate_sum = {1'b0, rate_ff} + RATE_ROUND;

   always_comb begin
      if (op == OP_FADE_IN) begin
         div_req.rem_init = '0;
         div_req.dividend = {rate_sum, {(DVD_BITS-RATE_BITS-1){1'b0}}};
         div_req.divisor  = RATE_DIV;
         div_req.steps    = RATE_STEPS;
      end else begin
         div_req.rem_init = {1'b0, num[CNT_BITS-1:1]};
         div_req.dividend = {num[0], {(DVD_BITS-1){1'b0}}};
         div_req.divisor  = tot_src;
         div_req.steps    = GAIN_STEPS;
      end
   end

   assign div_start = accept && ((op == OP_FADE_IN) || ((op == OP_FRAME) && act));

   always_comb begin
      if (div_q > QUO_BITS'(LEN_MAX))
         ramp_len = LEN_MAX;
      else if (div_q == '0)
         ramp_len = 12'd1;
      else
         ramp_len = div_q[CNT_BITS-1:0];
   end

   assign mul_start = (state_ff == ST_GAIN) && div_done;
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rate_in    = rate_ff;
      chan_in    = chan_ff;
      state_in   = state_ff;
      pending_in = pending_ff;
      rem_in     = rem_ff;
      total_in   = total_ff;
      active_in  = active_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SAMPLE_RATE: rate_in = csr_wdata[RATE_BITS-1:0];
            REG_ACTIVE_CH:   chan_in = csr_wdata[CHAN_BITS-1:0];
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_FRAME: begin
                     if (take)
                        pending_in = '0;
                     if (live) begin
                        rem_in   = rem_next;
                        total_in = (rem_next == '0) ? '0 : tot_src;
                     end else begin
                        rem_in   = '0;
                        total_in = '0;
                     end
                     active_in = act;
                     state_in  = act ? ST_GAIN : ST_DONE;
                  end
                  OP_FADE_IN: state_in = ST_LEN;
                  OP_CANCEL:  pending_in = '0;
                  default: ;
               endcase
            end
         end
         ST_LEN: begin
            if (div_done) begin
               if (pending_ff < ramp_len)
                  pending_in = ramp_len;
               state_in = ST_IDLE;
            end
         end
         ST_GAIN: begin
            if (div_done)
               state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done[0])
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (load_out) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            if (active_ff && (CHAN_BITS'(ch) < chan_ff))
               rsp_data_in[ch*SAMPLE_BITS +: SAMPLE_BITS] = mul_res[ch];
            else
               rsp_data_in[ch*SAMPLE_BITS +: SAMPLE_BITS] = sample_ff[ch];
         end
         rsp_user_in = active_ff;
      end
      if (load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         chan_ff      <= CHAN_RESET;
         pending_ff   <= '0;
         rem_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         chan_ff      <= chan_in;
         pending_ff   <= pending_in;
         rem_ff       <= rem_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      active_ff   <= active_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (accept && (op == OP_FRAME)) begin
         for (int ch = 0; ch < CHANNELS; ch++)
            sample_ff[ch] <= req_tdata[ch*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   lfir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      lfir_mul u_mul (
         .clock  (clock),
         .reset  (reset),
         .start  (mul_start),
         .sample (sample_ff[ch]),
         .gain   (div_q[GAIN_BITS-1:0]),
         .done   (mul_done[ch]),
         .result (mul_res[ch])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("divider busy while idle");

   a_rem_le_total: assert property (@(posedge clock) disable iff (reset)
      (rem_ff <= total_ff) && ((total_ff == '0) == (rem_ff == '0)))
      else $error("ramp counters inconsistent");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_LEN) || (state_ff == ST_GAIN)))
      else $error("divider result without a consumer");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (mul_done == '0) || (mul_done == '1))
      else $error("multiplier lanes out of step");

   a_gain_below_one: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (div_q[QUO_BITS-1] == 1'b0))
      else $error("ramp gain reached one inside a ramp");

endmodule

FILE: rtl/core/lfir_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lfir_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  lfir_pkg::div_req_type        req,
   output logic                         busy,
   output logic                         done,
   output logic [lfir_pkg::QUO_BITS-1:0] quotient
);
   import lfir_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]   rem_ff, rem_in;
   logic [DVD_BITS-1:0]   dvd_ff, dvd_in;
   logic [CNT_BITS-1:0]   dvs_ff, dvs_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS:0]     trial;
   logic [CNT_BITS:0]     diff;
   logic                  fits;

   assign trial = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps - 1'b1;
         rem_in  = req.rem_init;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
         dvd_in = {dvd_ff[DVD_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/lfir_mul.sv
// Bit-serial sign-magnitude sample by gain multiplier with round to nearest.
module lfir_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [lfir_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [lfir_pkg::GAIN_BITS-1:0]          gain,
   output logic                                   done,
   output logic signed [lfir_pkg::SAMPLE_BITS-1:0] result
);
   import lfir_pkg::*;

   localparam int CNT_W = $clog2(GAIN_BITS);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic [GAIN_BITS-1:0]   gain_ff, gain_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SAMPLE_BITS:0]   sum;
   logic [SAMPLE_BITS-1:0] rounded;

   assign sum = {1'b0, prod_ff[PROD_BITS-1:GAIN_BITS]}
              + {1'b0, (gain_ff[0] ? mag_ff : {SAMPLE_BITS{1'b0}})};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      gain_in = gain_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         neg_in  = sample[SAMPLE_BITS-1];
         mag_in  = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
         gain_in = gain;
         prod_in = '0;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[GAIN_BITS-1:1]};
         gain_in = {1'b0, gain_ff[GAIN_BITS-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      gain_ff <= gain_in;
      prod_ff <= prod_in;
   end

   assign rounded = prod_ff[PROD_BITS-1:GAIN_BITS]
                  + {{(SAMPLE_BITS-1){1'b0}}, prod_ff[GAIN_BITS-1]};
   assign result  = neg_ff ? -$signed(rounded) : $signed(rounded);
   assign done    = done_ff;

endmodule
